[hw/rtl/ubxnav_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxnav_pkg: shared types and constants of the UBX navigation frame receiver
// Byte classes passed from the frame front end to the back end, queue entry
// layout, protocol constants and the result bus layout.
// ----------------------------------------------------------------------------
package ubxnav_pkg;

	localparam logic [7:0] SYNC_ONE    = 8'hB5;
	localparam logic [7:0] SYNC_TWO    = 8'h62;
	localparam logic [7:0] POSITION_ID = 8'h02;
	localparam logic [7:0] CLASS_RESET = 8'h01;

	localparam int unsigned NUM_WORDS  = 6;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned MIN_LENGTH = 4;

	// result bus: frame_ok, message_id, six 32-bit words, zero padding to bytes
	localparam int unsigned RESULT_W   = 1 + 8 + NUM_WORDS * WORD_W;
	localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	// what the back end has to do with one byte
	typedef enum logic [2:0] {
		K_START   = 3'd0,  // class byte: restart sums, clear payload words
		K_ID      = 3'd1,  // message id: hold, add to sums
		K_LENGTH  = 3'd2,  // length byte: add to sums only
		K_PAYLOAD = 3'd3,  // payload byte: add to sums, maybe store
		K_CK_A    = 3'd4,  // first check byte: hold
		K_CK_B    = 3'd5   // second check byte: judge and emit result
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t  kind;
		logic [7:0]  data;
		logic        store;   // payload byte lands in a result word
		logic [2:0]  slot;    // which result word
		logic [1:0]  lane;    // byte lane within that word
		logic        len_ok;  // frame length at least the minimum
	} queue_entry_t;

endpackage

[hw/rtl/ubxnav_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxnav_front: frame tracker
// Hunts for sync, checks the class, follows length and payload position and
// tags every byte of an accepted frame from the class byte on for the back end.
// ----------------------------------------------------------------------------
module ubxnav_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [7:0]                 cfg_wdata,
	input  logic                       accept,
	input  logic [7:0]                 rx_byte,
	output logic                       push,
	output ubxnav_pkg::queue_entry_t   push_entry
);

	typedef enum logic [7:0] {
		PH_HUNT    = 8'b0000_0001,
		PH_SYNC2   = 8'b0000_0010,
		PH_DROP    = 8'b0000_0100,
		PH_CLASS   = 8'b0000_1000,
		PH_ID      = 8'b0001_0000,
		PH_LEN     = 8'b0010_0000,
		PH_PAYLOAD = 8'b0100_0000,
		PH_CHECK   = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  class_q;
	logic [15:0] len_q, len_n;
	logic [15:0] cnt_q, cnt_n;
	logic        len_hi_q, len_hi_n;
	logic        ck_hi_q, ck_hi_n;
	logic        len_ok_q, len_ok_n;
	logic        tag;
	ubxnav_pkg::byte_kind_t kind;
	logic [15:0] cnt_inc;
	logic [15:0] len_full;
	logic [13:0] group;
	logic        store;
	logic [2:0]  slot;

	assign cnt_inc  = cnt_q + 16'd1;
	assign len_full = {rx_byte, len_q[7:0]};
	assign group    = cnt_q[15:2];

	// payload words 0..3 and 5..6 feed the result; word 4 and beyond 6 only count
	always_comb begin
		store = 1'b1;
		slot  = 3'd0;
		if (group <= 14'd3) begin
			slot = group[2:0];
		end else if (group == 14'd5) begin
			slot = 3'd4;
		end else if (group == 14'd6) begin
			slot = 3'd5;
		end else begin
			store = 1'b0;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		len_n    = len_q;
		cnt_n    = cnt_q;
		len_hi_n = len_hi_q;
		ck_hi_n  = ck_hi_q;
		len_ok_n = len_ok_q;
		tag      = 1'b0;
		kind     = ubxnav_pkg::K_LENGTH;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == ubxnav_pkg::SYNC_ONE) begin
					phase_n = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				phase_n = (rx_byte == ubxnav_pkg::SYNC_TWO) ? PH_CLASS : PH_DROP;
			end
			PH_DROP: begin
				phase_n = PH_HUNT;
			end
			PH_CLASS: begin
				if (rx_byte != class_q) begin
					phase_n = PH_HUNT;
				end else begin
					tag     = 1'b1;
					kind    = ubxnav_pkg::K_START;
					phase_n = PH_ID;
				end
			end
			PH_ID: begin
				tag      = 1'b1;
				kind     = ubxnav_pkg::K_ID;
				len_hi_n = 1'b0;
				phase_n  = PH_LEN;
			end
			PH_LEN: begin
				tag  = 1'b1;
				kind = ubxnav_pkg::K_LENGTH;
				if (!len_hi_q) begin
					len_n    = {8'h00, rx_byte};
					len_hi_n = 1'b1;
				end else begin
					len_n    = len_full;
					len_hi_n = 1'b0;
					len_ok_n = (len_full >= 16'(ubxnav_pkg::MIN_LENGTH));
					cnt_n    = '0;
					ck_hi_n  = 1'b0;
					phase_n  = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				tag  = 1'b1;
				kind = ubxnav_pkg::K_PAYLOAD;
				if (cnt_inc >= len_q) begin
					cnt_n   = '0;
					ck_hi_n = 1'b0;
					phase_n = PH_CHECK;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_CHECK: begin
				tag = 1'b1;
				if (!ck_hi_q) begin
					kind    = ubxnav_pkg::K_CK_A;
					ck_hi_n = 1'b1;
				end else begin
					kind    = ubxnav_pkg::K_CK_B;
					ck_hi_n = 1'b0;
					phase_n = PH_HUNT;
				end
			end
			default: begin
				phase_n = PH_HUNT;
			end
		endcase
	end

	assign push              = accept && tag;
	assign push_entry.kind   = kind;
	assign push_entry.data   = rx_byte;
	assign push_entry.store  = store && (kind == ubxnav_pkg::K_PAYLOAD);
	assign push_entry.slot   = slot;
	assign push_entry.lane   = cnt_q[1:0];
	assign push_entry.len_ok = len_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			class_q  <= ubxnav_pkg::CLASS_RESET;
			len_q    <= '0;
			cnt_q    <= '0;
			len_hi_q <= 1'b0;
			ck_hi_q  <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				class_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q  <= phase_n;
				len_q    <= len_n;
				cnt_q    <= cnt_n;
				len_hi_q <= len_hi_n;
				ck_hi_q  <= ck_hi_n;
				len_ok_q <= len_ok_n;
			end
		end
	end

endmodule

[hw/rtl/ubxnav_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxnav_queue: tagged byte queue
// Small first-in first-out buffer between the frame tracker and the
// checksum/result back end.
// ----------------------------------------------------------------------------
module ubxnav_queue #(
	parameter int unsigned ADDR_W = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  ubxnav_pkg::queue_entry_t   push_entry,
	input  logic                       pop,
	output ubxnav_pkg::queue_entry_t   head,
	output logic                       empty,
	output logic                       full
);

	localparam int unsigned DEPTH = 1 << ADDR_W;

	ubxnav_pkg::queue_entry_t mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (ADDR_W+1)'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (ADDR_W+1)'(DEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/ubxnav_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxnav_back: checksum and result stage
// Runs the Fletcher-8 sums, gathers payload words and loads the result
// register when the second check byte comes through.
// ----------------------------------------------------------------------------
module ubxnav_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ubxnav_pkg::queue_entry_t               head,
	input  logic                                   empty,
	output logic                                   pop,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [ubxnav_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int unsigned PAD_W = ubxnav_pkg::OUT_TDATA_W - ubxnav_pkg::RESULT_W;

	logic [7:0] sum_a_q, sum_b_q;
	logic [7:0] id_q, ck_a_q;
	logic [ubxnav_pkg::WORD_W-1:0] words_q [ubxnav_pkg::NUM_WORDS];
	logic        valid_q;
	logic [ubxnav_pkg::OUT_TDATA_W-1:0] tdata_q;
	logic        out_free;
	logic        is_ckb;
	logic [7:0]  sum_a_add, sum_b_add;
	logic        frame_ok;
	logic        pos;
	logic [ubxnav_pkg::WORD_W-1:0] pos_mask;

	assign out_free  = !valid_q || m_tready;
	assign is_ckb    = (head.kind == ubxnav_pkg::K_CK_B);
	// hold a finished frame back only while the result register is occupied and not being taken
	assign pop       = !empty && (!is_ckb || out_free);
	assign sum_a_add = sum_a_q + head.data;
	assign sum_b_add = sum_b_q + sum_a_add;
	assign frame_ok  = (ck_a_q == sum_a_q) && (head.data == sum_b_q) && head.len_ok;
	assign pos       = (id_q == ubxnav_pkg::POSITION_ID);
	assign pos_mask  = {ubxnav_pkg::WORD_W{pos}};

	always_ff @(posedge clk) begin
		if (pop) begin
			case (head.kind)
				ubxnav_pkg::K_START: begin
					sum_a_q <= head.data;
					sum_b_q <= head.data;
					for (int i = 0; i < int'(ubxnav_pkg::NUM_WORDS); i++) begin
						words_q[i] <= '0;
					end
				end
				ubxnav_pkg::K_ID: begin
					id_q    <= head.data;
					sum_a_q <= sum_a_add;
					sum_b_q <= sum_b_add;
				end
				ubxnav_pkg::K_LENGTH: begin
					sum_a_q <= sum_a_add;
					sum_b_q <= sum_b_add;
				end
				ubxnav_pkg::K_PAYLOAD: begin
					sum_a_q <= sum_a_add;
					sum_b_q <= sum_b_add;
					if (head.store) begin
						words_q[head.slot][{head.lane, 3'b000} +: 8] <= head.data;
					end
				end
				ubxnav_pkg::K_CK_A: begin
					ck_a_q <= head.data;
				end
				ubxnav_pkg::K_CK_B: begin
					tdata_q <= {{PAD_W{1'b0}},
						words_q[5] & pos_mask,
						words_q[4] & pos_mask,
						words_q[3] & pos_mask,
						words_q[2] & pos_mask,
						words_q[1] & pos_mask,
						words_q[0],
						id_q,
						frame_ok};
				end
				default: begin
					ck_a_q <= ck_a_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && is_ckb) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = tdata_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_ckb) |-> out_free) else $error("result overwritten before taken");

endmodule

[hw/rtl/ubx_nav_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_nav_frame_receiver_core: UBX navigation frame receiver
// Parses UBX frames from a byte stream, checks the Fletcher-8 sums and reports
// one result per frame with the time of week and, for id 2, the position.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received serial bytes on the s_* stream, one byte per transaction.
//   Each frame of the configured class that completes its second check byte
//   yields exactly one transaction on the m_* stream; bytes outside frames,
//   bad sync and wrong class frames produce nothing.
//   A byte is taken every cycle while the internal queue has room, so the
//   sustained rate is one byte per cycle. The frame tracker hands tagged bytes
//   to the checksum stage through a 2**QUEUE_ADDR_W deep queue (4 entries by
//   default); the result appears on m_tvalid once the second check byte has
//   passed through the queue into the output register.
//   If the downstream side stalls, one result waits in the output register
//   while later bytes keep flowing into the queue; only the next frame's
//   final check byte waits, and s_tready drops once the queue fills.
//   Write the class filter through cfg_we/cfg_wdata while the block is idle.
//   Reset (arst_n low) returns to sync hunting, sets the class filter to 1,
//   empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module ubx_nav_frame_receiver_core #(
	parameter int unsigned QUEUE_ADDR_W = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// class filter register
	input  logic                                cfg_we,
	input  logic [7:0]                          cfg_wdata,
	// received bytes
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	// frame results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] frame_ok, [8:1] message_id, [40:9] time_of_week, [72:41] longitude,
	// [104:73] latitude, [136:105] height_mm, [168:137] horiz_accuracy,
	// [200:169] vert_accuracy, [207:201] zero
	output logic [ubxnav_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic                     accept;
	logic                     push;
	logic                     pop;
	logic                     q_empty;
	logic                     q_full;
	ubxnav_pkg::queue_entry_t push_entry;
	ubxnav_pkg::queue_entry_t head;

	// take bytes whenever the queue can absorb one more
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	ubxnav_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.rx_byte    (s_tdata),
		.push       (push),
		.push_entry (push_entry)
	);

	ubxnav_queue #(
		.ADDR_W (QUEUE_ADDR_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	ubxnav_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
